// ----- src/ppfl_pkg.sv -----
// Shared codes and types of the per-CPU free-list page allocator.
package ppfl_pkg;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_BAD   = 2'd2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef logic csr_index_type;

   localparam csr_index_type CSR_REGION_START = 1'b0;
   localparam csr_index_type CSR_REGION_STOP  = 1'b1;

   localparam logic [31:0] REGION_START_RESET = 32'h8000_0000;
   localparam logic [31:0] REGION_STOP_RESET  = 32'h8800_0000;

   // Width of the shared add/subtract unit: two 33-bit operands plus a borrow bit.
   localparam int UNIT_W = 34;

endpackage

// ----- src/percpu_page_free_list_allocator.sv -----
// Top level of the per-CPU free-list page allocator.
//
// Page allocator with one LIFO free list per CPU. Each list is a non-empty flag,
// a head register (page number + 1) and a next-link memory of MAX_PAGES words
// indexed by page number, counted from region_start rounded up to PAGE_BYTES.
// A free transaction checks the address (aligned, within [region_start,
// region_stop), page number below MAX_PAGES) and pushes it onto the list of the
// requesting CPU, or returns status 2 and changes nothing. An alloc transaction
// pops the requester's own list, else steals from the lowest-numbered
// non-empty list, else returns status 1 with address 0. The cpu field is taken
// modulo CPU_COUNT. One transaction is worked on at a time: a small sequencer
// drives a single 34-bit add/subtract unit through the base rounding, the range
// checks and the address rebuild, and the link memory gives one registered read
// per pop. Alloc steps: base, pop read, pop write-back, done (base to done when
// every list is empty). Free steps: base, low and high check, index, push, done
// (no push when refused). The next request is accepted once the result register
// loads, even while the result still waits on rsp.
// The link memory needs no clearing pass; a link is only read for a page that
// was pushed. PAGE_BYTES must be a power of two.
module percpu_page_free_list_allocator #(
   parameter int CPU_COUNT  = 8,
   parameter int MAX_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_we,
   input  ppfl_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [2:0]             req_cpu,
   input  logic [31:0]            req_page_addr,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ppfl_pkg::status_type   rsp_status,
   output logic [31:0]            rsp_granted_addr,
   output logic [2:0]             rsp_source_list
);

   localparam int LW       = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
   localparam int IW       = $clog2(MAX_PAGES);
   localparam int HW       = $clog2(MAX_PAGES + 1);
   localparam int PB_SHIFT = $clog2(PAGE_BYTES);
   localparam int UW       = ppfl_pkg::UNIT_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_BASE   = 4'd1;
   localparam logic [3:0] S_CHK_LO = 4'd2;
   localparam logic [3:0] S_CHK_HI = 4'd3;
   localparam logic [3:0] S_IDX    = 4'd4;
   localparam logic [3:0] S_PUSH   = 4'd5;
   localparam logic [3:0] S_POP_RD = 4'd6;
   localparam logic [3:0] S_POP_WB = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   localparam logic [32:0] PB_MASK = 33'(PAGE_BYTES - 1);

   // Configuration
   logic [31:0] region_start_ff;
   logic [31:0] region_stop_ff;

   // Sequencer and transaction context
   logic [3:0]           state_ff;
   logic [3:0]           state_in;
   logic                 action_ff;
   logic [31:0]          addr_ff;
   logic [LW-1:0]        list_ff;
   logic                 bad_ff;
   logic [32:0]          base_ff;
   logic [IW-1:0]        idx_ff;
   ppfl_pkg::status_type res_status_ff;
   logic [31:0]          res_granted_ff;

   // List state: heads in flops guarded by non-empty flags, links in memory
   logic [HW-1:0]        heads_ff [CPU_COUNT];
   logic [CPU_COUNT-1:0] nonempty_ff;
   logic [HW-1:0]        links_mem [MAX_PAGES];
   logic [HW-1:0]        link_rdata_ff;

   // Result register
   logic                 rsp_valid_ff;
   ppfl_pkg::status_type rsp_status_ff;
   logic [31:0]          rsp_granted_ff;
   logic [2:0]           rsp_source_ff;

   // Shared arithmetic unit
   logic [UW-1:0] unit_a;
   logic [UW-1:0] unit_b;
   logic          unit_sub;
   logic [UW-1:0] unit_res;

   logic [LW-1:0] cpu_mod;
   logic [LW-1:0] steal_list;
   logic [HW-1:0] head_dec;
   logic [IW-1:0] pop_idx;
   logic [32:0]   page_off;
   logic          rsp_slot_free;

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_addr = rsp_granted_ff;
   assign rsp_source_list  = rsp_source_ff;
   assign rsp_slot_free    = !rsp_valid_ff || rsp_ready;

   assign head_dec = heads_ff[list_ff] - HW'(1);
   assign pop_idx  = head_dec[IW-1:0];
   assign page_off = unit_res[32:0] >> PB_SHIFT;

   // Fold the cpu field onto the lists present, one constant entry per code.
   always_comb begin
      cpu_mod = '0;
      for (int i = 0; i < 8; i++) begin
         if (req_cpu == 3'(i)) begin
            cpu_mod = LW'(i % CPU_COUNT);
         end
      end
   end

   // Lowest-numbered non-empty list, used when the own list is empty.
   always_comb begin
      steal_list = '0;
      for (int i = CPU_COUNT - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            steal_list = LW'(i);
         end
      end
   end

   // Operand selection for the shared add/subtract unit.
   always_comb begin
      unit_a   = '0;
      unit_b   = '0;
      unit_sub = 1'b0;
      unique case (state_ff)
         S_BASE: begin
            unit_a = UW'(region_start_ff);
            unit_b = UW'(PB_MASK);
         end
         S_CHK_LO: begin
            unit_a   = UW'(addr_ff);
            unit_b   = UW'(region_start_ff);
            unit_sub = 1'b1;
         end
         S_CHK_HI: begin
            unit_a   = UW'(addr_ff);
            unit_b   = UW'(region_stop_ff);
            unit_sub = 1'b1;
         end
         S_IDX: begin
            unit_a   = UW'(addr_ff);
            unit_b   = UW'(base_ff);
            unit_sub = 1'b1;
         end
         S_POP_WB: begin
            unit_a = UW'(base_ff);
            unit_b = UW'(idx_ff) << PB_SHIFT;
         end
         default: begin
            unit_a   = '0;
            unit_b   = '0;
            unit_sub = 1'b0;
         end
      endcase
   end

   assign unit_res = unit_a + (unit_sub ? ~unit_b : unit_b) + UW'(unit_sub);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            if (action_ff == ppfl_pkg::ACT_FREE) begin
               state_in = S_CHK_LO;
            end else if (nonempty_ff != '0) begin
               state_in = S_POP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CHK_LO: state_in = S_CHK_HI;
         S_CHK_HI: state_in = S_IDX;
         S_IDX: begin
            if (bad_ff || unit_res[UW-1] || (page_off >= 33'(MAX_PAGES))) begin
               state_in = S_DONE;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH:   state_in = S_DONE;
         S_POP_RD: state_in = S_POP_WB;
         S_POP_WB: state_in = S_DONE;
         S_DONE: begin
            if (rsp_slot_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         nonempty_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         region_start_ff <= ppfl_pkg::REGION_START_RESET;
         region_stop_ff  <= ppfl_pkg::REGION_STOP_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               ppfl_pkg::CSR_REGION_START: region_start_ff <= csr_wdata;
               ppfl_pkg::CSR_REGION_STOP:  region_stop_ff  <= csr_wdata;
               default: ;
            endcase
         end
         // Set the list flag on push, refresh it from the link word on pop.
         if (state_ff == S_PUSH) begin
            nonempty_ff[list_ff] <= 1'b1;
         end else if (state_ff == S_POP_WB) begin
            nonempty_ff[list_ff] <= (link_rdata_ff != '0);
         end
         if (state_ff == S_DONE && rsp_slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               action_ff      <= req_action;
               addr_ff        <= req_page_addr;
               list_ff        <= cpu_mod;
               bad_ff         <= (req_page_addr[PB_SHIFT-1:0] != '0);
               res_status_ff  <= ppfl_pkg::STATUS_OK;
               res_granted_ff <= '0;
            end
         end
         S_BASE: begin
            // Round region_start up to a page boundary.
            base_ff <= unit_res[32:0] & ~PB_MASK;
            if (action_ff == ppfl_pkg::ACT_ALLOC) begin
               if (nonempty_ff == '0) begin
                  res_status_ff <= ppfl_pkg::STATUS_EMPTY;
               end else if (!nonempty_ff[list_ff]) begin
                  list_ff <= steal_list;
               end
            end
         end
         S_CHK_LO: begin
            if (unit_res[UW-1]) begin
               bad_ff <= 1'b1;
            end
         end
         S_CHK_HI: begin
            if (!unit_res[UW-1]) begin
               bad_ff <= 1'b1;
            end
         end
         S_IDX: begin
            idx_ff <= page_off[IW-1:0];
            if (bad_ff || unit_res[UW-1] || (page_off >= 33'(MAX_PAGES))) begin
               res_status_ff <= ppfl_pkg::STATUS_BAD;
            end
         end
         S_PUSH: begin
            heads_ff[list_ff] <= HW'(idx_ff) + HW'(1);
         end
         S_POP_RD: begin
            idx_ff <= pop_idx;
         end
         S_POP_WB: begin
            heads_ff[list_ff] <= link_rdata_ff;
            res_granted_ff    <= unit_res[31:0];
         end
         S_DONE: begin
            if (rsp_slot_free) begin
               rsp_status_ff  <= res_status_ff;
               rsp_granted_ff <= res_granted_ff;
               rsp_source_ff  <= 3'(list_ff);
            end
         end
         default: ;
      endcase
   end

   // Next-link memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == S_PUSH) begin
         // An empty list ends the chain, whatever its stale head register holds.
         links_mem[idx_ff] <= nonempty_ff[list_ff] ? heads_ff[list_ff] : '0;
      end
      if (state_ff == S_POP_RD) begin
         link_rdata_ff <= links_mem[pop_idx];
      end
   end

   // A result only appears out of the completion step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside completion step");

   // A pop only starts on a list that holds pages.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_RD) |-> nonempty_ff[list_ff])
      else $error("pop started on an empty list");

   // An empty status means every list really is empty.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_status_ff == ppfl_pkg::STATUS_EMPTY) |->
         (nonempty_ff == '0))
      else $error("empty status while a list holds pages");

   // A push leaves the target list non-empty.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH) |=> nonempty_ff[$past(list_ff)])
      else $error("list still empty after push");

endmodule
